[design/lctp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the Lehmer code to permutation decoder.
// Used by lctp_cfg, lctp_walk and the top module; depends on nothing else.
package lctp_pkg;

	localparam int MAX_LEN = 1024;
	localparam int LVL_N   = $clog2(MAX_LEN);
	localparam int LVL_W   = $clog2(LVL_N + 1);
	localparam int LEN_W   = LVL_N + 1;
	localparam int DIGIT_W = 10;
	localparam int CNT_W   = LVL_N;
	localparam int NODE_W  = LVL_N + 1;
	localparam int ADDR_W  = LVL_N;
	localparam int J_W     = LVL_N - 1;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [PADDR_W-1:0] REG_SEQ_LENGTH = 3'd0;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic             restart;
	} cfg_t;

	typedef struct packed {
		logic [LEN_W-1:0] value;
		logic             last;
		logic             bad;
	} res_t;

endpackage

[design/lctp_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; a read of the address being written returns the old data.
module lctp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/lctp_cfg.sv]
`timescale 1ns / 1ps
// APB register file holding seq_length, with the clamped effective length.
// Depends on lctp_pkg.
module lctp_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lctp_pkg::PADDR_W-1:0]    paddr,
	input  logic [lctp_pkg::PDATA_W-1:0]    pwdata,
	output logic [lctp_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready,
	output lctp_pkg::cfg_t                  cfg
);

	logic [lctp_pkg::LEN_W-1:0] seq_length_q;
	logic                       hit;
	logic                       wr;

	assign pready = 1'b1;
	assign hit    = ({paddr[lctp_pkg::PADDR_W-1:2], 2'b00} == lctp_pkg::REG_SEQ_LENGTH);
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_length_q <= lctp_pkg::LEN_W'(1);
		end else if (wr && hit) begin
			seq_length_q <= pwdata[lctp_pkg::LEN_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = lctp_pkg::PDATA_W'(seq_length_q);
		end
	end

	always_comb begin
		cfg.restart = wr && hit;
		if (seq_length_q == '0) begin
			cfg.len = lctp_pkg::LEN_W'(1);
		end else if (seq_length_q > lctp_pkg::LEN_W'(lctp_pkg::MAX_LEN)) begin
			cfg.len = lctp_pkg::LEN_W'(lctp_pkg::MAX_LEN);
		end else begin
			cfg.len = seq_length_q;
		end
	end

endmodule

[design/lctp_walk.sv]
`timescale 1ns / 1ps
// Sequencer that refills the count tree and walks it one level per cycle.
// Depends on lctp_pkg and lctp_ram; the RAM holds the left-child count of each node.
module lctp_walk (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lctp_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lctp_pkg::DIGIT_W-1:0]  in_digit,
	output logic                          res_valid,
	input  logic                          res_ready,
	output lctp_pkg::res_t                res
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLEAR = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_DESC  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]                        state_q;
	logic [lctp_pkg::LVL_N-1:0]        pos_q;
	logic [lctp_pkg::LEN_W-1:0]        root_q;
	logic [lctp_pkg::LEN_W-1:0]        k_q;
	logic [lctp_pkg::NODE_W-1:0]       node_q;
	logic [lctp_pkg::LVL_W-1:0]        lvl_q;
	logic [lctp_pkg::J_W-1:0]          j_q;
	logic                              bad_q;

	logic                              ram_we;
	logic [lctp_pkg::ADDR_W-1:0]       ram_waddr;
	logic [lctp_pkg::CNT_W-1:0]        ram_wdata;
	logic [lctp_pkg::ADDR_W-1:0]       ram_raddr;
	logic [lctp_pkg::CNT_W-1:0]        ram_rdata;

	logic [lctp_pkg::LEN_W-1:0]        digit_ext;
	logic [lctp_pkg::LEN_W-1:0]        left_cnt;
	logic                              go_left;
	logic [lctp_pkg::NODE_W-1:0]       child;
	logic [lctp_pkg::LVL_N-1:0]        clr_base;
	logic [lctp_pkg::LEN_W:0]          clr_diff;
	logic [lctp_pkg::LEN_W-1:0]        clr_size;
	logic [lctp_pkg::CNT_W-1:0]        clr_init;
	logic [lctp_pkg::ADDR_W-1:0]       clr_addr;
	logic [lctp_pkg::J_W-1:0]          j_last;
	logic                              accept;
	logic                              pos_last;

	lctp_ram #(
		.WIDTH(lctp_pkg::CNT_W),
		.DEPTH(lctp_pkg::MAX_LEN)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign digit_ext = lctp_pkg::LEN_W'(in_digit);
	assign left_cnt  = lctp_pkg::LEN_W'(ram_rdata);
	assign go_left   = (k_q <= left_cnt);
	assign child     = {node_q[lctp_pkg::LVL_N-1:0], !go_left};
	assign pos_last  = ((lctp_pkg::LEN_W'(pos_q) + lctp_pkg::LEN_W'(1)) >= cfg.len);

	// Clearing pass: node (1 << lvl) | j holds the number of values 1..len in its left child.
	assign clr_addr = lctp_pkg::ADDR_W'((lctp_pkg::ADDR_W'(1) << lvl_q) | lctp_pkg::ADDR_W'(j_q));
	assign clr_base = lctp_pkg::LVL_N'(lctp_pkg::LVL_N'(j_q)
		<< (lctp_pkg::LVL_W'(lctp_pkg::LVL_N) - lvl_q));
	assign clr_diff = {1'b0, cfg.len} - (lctp_pkg::LEN_W + 1)'(clr_base);
	assign clr_size = lctp_pkg::LEN_W'(1) << (lctp_pkg::LVL_W'(lctp_pkg::LVL_N - 1) - lvl_q);
	assign j_last   = lctp_pkg::J_W'((lctp_pkg::LVL_N'(1) << lvl_q) - lctp_pkg::LVL_N'(1));

	always_comb begin
		if (clr_diff[lctp_pkg::LEN_W]) begin
			clr_init = '0;
		end else if (clr_diff[lctp_pkg::LEN_W-1:0] >= clr_size) begin
			clr_init = clr_size[lctp_pkg::CNT_W-1:0];
		end else begin
			clr_init = clr_diff[lctp_pkg::CNT_W-1:0];
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_addr;
		ram_wdata = clr_init;
		ram_raddr = lctp_pkg::ADDR_W'(1);
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_DESC: begin
				ram_we    = go_left;
				ram_waddr = node_q[lctp_pkg::ADDR_W-1:0];
				ram_wdata = ram_rdata - lctp_pkg::CNT_W'(1);
				ram_raddr = child[lctp_pkg::ADDR_W-1:0];
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign res_valid = (state_q == ST_DONE);
	assign res.value = bad_q ? '0
		: lctp_pkg::LEN_W'(node_q[lctp_pkg::LVL_N-1:0]) + lctp_pkg::LEN_W'(1);
	assign res.last  = pos_last;
	assign res.bad   = bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			root_q  <= '0;
			k_q     <= '0;
			node_q  <= '0;
			lvl_q   <= '0;
			j_q     <= '0;
			bad_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg.restart) begin
						pos_q <= '0;
					end
					if (accept) begin
						k_q <= digit_ext + lctp_pkg::LEN_W'(1);
						if (pos_q == '0) begin
							root_q  <= cfg.len;
							lvl_q   <= '0;
							j_q     <= '0;
							state_q <= ST_CLEAR;
						end else if (digit_ext >= root_q) begin
							bad_q   <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							bad_q   <= 1'b0;
							root_q  <= root_q - lctp_pkg::LEN_W'(1);
							node_q  <= lctp_pkg::NODE_W'(1);
							lvl_q   <= '0;
							state_q <= ST_DESC;
						end
					end
				end
				ST_CLEAR: begin
					if (j_q == j_last) begin
						j_q <= '0;
						if (lvl_q == lctp_pkg::LVL_W'(lctp_pkg::LVL_N - 1)) begin
							state_q <= ST_CHECK;
						end else begin
							lvl_q <= lvl_q + lctp_pkg::LVL_W'(1);
						end
					end else begin
						j_q <= j_q + lctp_pkg::J_W'(1);
					end
				end
				ST_CHECK: begin
					if (k_q > root_q) begin
						bad_q   <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						bad_q   <= 1'b0;
						root_q  <= root_q - lctp_pkg::LEN_W'(1);
						node_q  <= lctp_pkg::NODE_W'(1);
						lvl_q   <= '0;
						state_q <= ST_DESC;
					end
				end
				ST_DESC: begin
					if (!go_left) begin
						k_q <= k_q - left_cnt;
					end
					node_q <= child;
					lvl_q  <= lvl_q + lctp_pkg::LVL_W'(1);
					if (lvl_q == lctp_pkg::LVL_W'(lctp_pkg::LVL_N - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						pos_q   <= pos_last ? '0 : pos_q + lctp_pkg::LVL_N'(1);
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[design/lehmer_code_to_permutation.sv]
`timescale 1ns / 1ps
// Lehmer code to permutation decoder: each digit beat on the input stream gives
// one element of a permutation of 1..seq_length on the output stream.
// Input beat: s_axis_tdata holds the digit. Output beat: s/m data as listed at the ports;
// m_axis_tlast marks the final element of a sequence and m_axis_tuser flags a digit
// that was not below the count of values still remaining (value 0, nothing removed).
// seq_length is written through the APB port at address 0 while the block is idle;
// any write restarts the sequence. 0 acts as 1 and values above 1024 act as 1024.
// The first digit of every sequence starts a refill of the 1023 used entries of the
// 1024-entry count RAM, one entry a cycle, followed by a range check.
// A good digit walks the ten-level count tree from the root to a leaf with a single
// compare-and-subtract unit, with one RAM read each cycle and a RAM write whenever the
// walk goes left, and is handed off to the output register. A bad digit skips the walk.
// s_axis_tready rises when the block returns to idle after the hand-off, so a new digit
// is taken only once the last one has been handed off. One digit is in work at a time.
// A stalled receiver holds the result in the output register and the block
// waits for the register to free before finishing the next digit.
// After reset seq_length is 1, the sequence position is 0 and no beat is pending.
module lehmer_code_to_permutation (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [15:0]                    s_axis_tdata,   // [9:0] digit
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [15:0]                    m_axis_tdata,   // [10:0] value
	output logic                           m_axis_tlast,   // last element of the sequence
	output logic                           m_axis_tuser,   // [0] bad_digit
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lctp_pkg::PADDR_W-1:0]   paddr,
	input  logic [lctp_pkg::PDATA_W-1:0]   pwdata,
	output logic [lctp_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);

	lctp_pkg::cfg_t              cfg;
	lctp_pkg::res_t              res;
	logic                        res_valid;
	logic                        res_ready;
	logic                        out_valid_q;
	logic [lctp_pkg::LEN_W-1:0]  out_value_q;
	logic                        out_last_q;
	logic                        out_bad_q;

	lctp_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	lctp_walk u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_digit (s_axis_tdata[lctp_pkg::DIGIT_W-1:0]),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_value_q <= res.value;
			out_last_q  <= res.last;
			out_bad_q   <= res.bad;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = 16'(out_value_q);
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_bad_q;

	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'd0)
		else $error("bad digit beat carries a nonzero value");

	a_value_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |->
			m_axis_tdata[lctp_pkg::LEN_W-1:0] != '0
			&& m_axis_tdata[lctp_pkg::LEN_W-1:0] <= cfg.len)
		else $error("decoded value outside 1..length");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready again right after a beat was taken");

endmodule

[dv/lehmer_code_to_permutation_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for lehmer_code_to_permutation: Lehmer digits are streamed in
// phases of different sequence lengths with random idling on both sides, and every
// output beat is checked against a local model of the unused values. Needs lctp_pkg.
module lehmer_code_to_permutation_test;
	import lctp_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 5_000_000;
	localparam int unsigned RANDOM_ITEMS = 1125;
	localparam int unsigned CALM_AFTER   = 1000;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [15:0]         s_axis_tdata  = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [15:0]         m_axis_tdata;
	logic                m_axis_tlast;
	logic                m_axis_tuser;
	logic                psel          = 1'b0;
	logic                penable       = 1'b0;
	logic                pwrite        = 1'b0;
	logic [PADDR_W-1:0]  paddr         = '0;
	logic [PDATA_W-1:0]  pwdata        = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	lehmer_code_to_permutation dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	logic [DIGIT_W-1:0] lehmer_digits[$];
	res_t               pending_elements[$];

	logic [LEN_W-1:0]   cfg_length   = 11'd1;
	int unsigned        elem_index   = 0;
	bit                 unused_values[1:MAX_LEN];
	int unsigned        unused_count = 0;

	bit                 calm         = 1'b0;
	int unsigned        send_gap     = 0;
	int unsigned        recv_stall   = 0;
	int unsigned        errors       = 0;
	int unsigned        cycles       = 0;
	int unsigned        beats_sent   = 0;
	int unsigned        beats_seen   = 0;
	int unsigned        seqs_closed  = 0;
	int unsigned        bad_seen     = 0;
	int unsigned        phases       = 0;

	function automatic int unsigned clamp_length(logic [LEN_W-1:0] len);
		if (len == 0)
			return 1;
		if (len > MAX_LEN)
			return MAX_LEN;
		return int'(len);
	endfunction

	// Picks the (digit+1)-th smallest unused value and retires it; the pool is
	// refilled with 1..length on the first digit of every sequence.
	function automatic res_t decode_digit(logic [DIGIT_W-1:0] digit);
		int unsigned eff;
		int unsigned rank;
		bit          found;
		res_t        r;
		eff = clamp_length(cfg_length);
		r = '0;
		if (elem_index >= eff)
			elem_index = 0;
		if (elem_index == 0) begin
			for (int v = 1; v <= MAX_LEN; v++)
				unused_values[v] = (v <= eff);
			unused_count = eff;
		end
		if (digit >= unused_count) begin
			r.bad = 1'b1;
		end else begin
			rank = digit;
			found = 1'b0;
			for (int v = 1; v <= MAX_LEN; v++) begin
				if (!found && unused_values[v]) begin
					if (rank == 0) begin
						found = 1'b1;
						r.value = LEN_W'(v);
						unused_values[v] = 1'b0;
						unused_count--;
					end else begin
						rank--;
					end
				end
			end
		end
		if (elem_index + 1 >= eff) begin
			r.last = 1'b1;
			elem_index = 0;
		end else begin
			elem_index++;
		end
		return r;
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
			$display("lehmer_code_to_permutation_test failed");
			$finish;
		end
	end

	// Digit driver: holds a beat until it is taken, and idles in random bursts.
	always @(posedge clk or negedge arst_n) begin
		logic               next_valid;
		logic [DIGIT_W-1:0] next_digit;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				pending_elements.push_back(decode_digit(s_axis_tdata[DIGIT_W-1:0]));
				beats_sent++;
			end
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				next_valid = 1'b0;
				next_digit = s_axis_tdata[DIGIT_W-1:0];
				if (send_gap > 0) begin
					send_gap--;
				end else if (lehmer_digits.size() > 0) begin
					if (!calm && $urandom_range(0, 5) == 0) begin
						send_gap = $urandom_range(0, 9);
					end else begin
						next_valid = 1'b1;
						next_digit = lehmer_digits.pop_front();
					end
				end
				s_axis_tvalid <= next_valid;
				s_axis_tdata  <= {{(16 - DIGIT_W){1'b0}}, next_digit};
			end
		end
	end

	// Element monitor: compares every output beat with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				beats_seen++;
				if (pending_elements.size() == 0) begin
					$display("%0t: unexpected beat: tdata=%0d tlast=%0b tuser=%0b",
						$time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
					errors++;
				end else begin
					want = pending_elements.pop_front();
					if (m_axis_tdata !== {{(16 - LEN_W){1'b0}}, want.value} ||
						m_axis_tlast !== want.last || m_axis_tuser !== want.bad) begin
						$display("%0t: expected %0d/%0b/%0b, got %0d/%0b/%0b",
							$time, want.value, want.last, want.bad,
							m_axis_tdata, m_axis_tlast, m_axis_tuser);
						errors++;
					end
					if (want.last)
						seqs_closed++;
					if (want.bad)
						bad_seen++;
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				m_axis_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				recv_stall = $urandom_range(0, 9);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic write_length(input logic [LEN_W-1:0] len);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_SEQ_LENGTH;
		pwdata  <= {{(PDATA_W - LEN_W){1'b0}}, len};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cfg_length = len;
		elem_index = 0;
		phases++;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (lehmer_digits.size() != 0 || s_axis_tvalid || pending_elements.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [LEN_W-1:0]   len;
		int unsigned        eff;
		int unsigned        count;
		int unsigned        left;
		int unsigned        pos;
		int unsigned        queued;
		logic [DIGIT_W-1:0] digit;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset the length is one: a good digit and an out-of-range one.
		lehmer_digits.push_back(10'd0);
		lehmer_digits.push_back(10'd1023);
		wait_idle();

		// A length of zero behaves as one.
		write_length(11'd0);
		lehmer_digits.push_back(10'd0);
		lehmer_digits.push_back(10'd1);
		wait_idle();

		// A full permutation, then a sequence that ends on a bad digit, then a bad first digit.
		write_length(11'd4);
		lehmer_digits.push_back(10'd3);
		lehmer_digits.push_back(10'd0);
		lehmer_digits.push_back(10'd1);
		lehmer_digits.push_back(10'd0);
		lehmer_digits.push_back(10'd0);
		lehmer_digits.push_back(10'd0);
		lehmer_digits.push_back(10'd0);
		lehmer_digits.push_back(10'd5);
		lehmer_digits.push_back(10'd1023);
		wait_idle();

		// Lengths above the maximum saturate; the top digit is good only at first.
		write_length(11'd2047);
		lehmer_digits.push_back(10'd1023);
		lehmer_digits.push_back(10'd0);
		lehmer_digits.push_back(10'd1023);
		lehmer_digits.push_back(10'd512);
		lehmer_digits.push_back(10'd511);
		wait_idle();

		// Rewriting the length in the middle of a sequence starts a fresh one.
		write_length(11'd3);
		lehmer_digits.push_back(10'd2);
		lehmer_digits.push_back(10'd1);
		lehmer_digits.push_back(10'd0);
		lehmer_digits.push_back(10'd1);
		wait_idle();

		write_length(11'd1024);
		lehmer_digits.push_back(10'd1023);
		lehmer_digits.push_back(10'd0);
		lehmer_digits.push_back(10'd682);
		wait_idle();

		// Random phases: mostly short lengths with well-formed codes, a little noise.
		queued = 0;
		while (queued < RANDOM_ITEMS) begin
			if (queued >= CALM_AFTER)
				calm = 1'b1;
			case ($urandom_range(0, 19))
				0:       len = 11'd0;
				1:       len = 11'd1024;
				2:       len = 11'd2047;
				3, 4:    len = LEN_W'($urandom_range(201, 2047));
				5, 6, 7: len = LEN_W'($urandom_range(13, 200));
				default: len = LEN_W'($urandom_range(1, 12));
			endcase
			eff = clamp_length(len);
			if (eff <= 12)
				count = eff * $urandom_range(1, 4);
			else if (eff <= 200)
				count = eff;
			else
				count = $urandom_range(16, 64);
			if (eff <= 200 && $urandom_range(0, 3) == 0)
				count += $urandom_range(0, eff - 1);
			if (count > RANDOM_ITEMS - queued)
				count = RANDOM_ITEMS - queued;
			write_length(len);
			pos = 0;
			left = eff;
			for (int n = 0; n < count; n++) begin
				if (pos == 0)
					left = eff;
				case ($urandom_range(0, 19))
					0:       digit = DIGIT_W'($urandom_range(0, 1023));
					1:       digit = (left > 1023) ? 10'd1023 : DIGIT_W'(left);
					default: digit = DIGIT_W'($urandom_range(0, left - 1));
				endcase
				if (digit < left)
					left--;
				pos = (pos + 1 == eff) ? 0 : pos + 1;
				lehmer_digits.push_back(digit);
			end
			queued += count;
			wait_idle();
		end

		repeat (30) @(posedge clk);
		if (pending_elements.size() != 0) begin
			$display("%0t: %0d expected elements never arrived", $time, pending_elements.size());
			errors++;
		end
		$display("Decoded %0d digits over %0d length settings; %0d beats checked.",
			beats_sent, phases, beats_seen);
		$display("Closed %0d sequences and saw %0d bad digits; %0d mismatches.",
			seqs_closed, bad_seen, errors);
		if (errors == 0)
			$display("lehmer_code_to_permutation_test passed");
		else
			$display("lehmer_code_to_permutation_test failed");
		$finish;
	end

endmodule

[filelist.f]
design/lctp_pkg.sv
design/lctp_ram.sv
design/lctp_cfg.sv
design/lctp_walk.sv
design/lehmer_code_to_permutation.sv
dv/lehmer_code_to_permutation_test.sv
